// File: hdl/pgn_pkg.sv
// shared constants, command codes and lane control struct for the perlin noise block
package pgn_pkg;

    localparam int TABLE_SIZE_DEF      = 256;
    localparam int MAX_OCTAVES_DEF     = 8;
    localparam int COORD_FRAC_BITS_DEF = 16;

    localparam int POINT_W     = 32;
    // point sign-extended far enough for the largest octave shift
    localparam int QUERY_W     = POINT_W + 16;
    localparam int LANE_STAGES = 8;
    localparam int NUM_STAGES  = 10;
    localparam int OUT_W       = 24;

    localparam logic [1:0] CMD_GRAD   = 2'd0;
    localparam logic [1:0] CMD_PERM   = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_OCTAVE = 1'b1;

    typedef struct packed {
        logic [LANE_STAGES:1] en;
        logic                 perm_we;
        logic                 grad_we;
        logic [7:0]           perm_idx;
        logic [7:0]           grad_idx;
        logic [7:0]           perm_x;
        logic [7:0]           perm_y;
        logic [7:0]           perm_z;
        logic [15:0]          grad_x;
        logic [15:0]          grad_y;
        logic [15:0]          grad_z;
    } pgn_ctl_t;

endpackage

// File: hdl/pgn_lane.sv
// one octave of the noise pipeline: lattice split, table lookups, dot products, lerps
module pgn_lane
    import pgn_pkg::*;
#(
    parameter int TABLE_SIZE      = TABLE_SIZE_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int OCTAVE          = 0
)
(
    input  logic                                  clk,
    input  pgn_ctl_t                              ctl,
    input  logic signed [POINT_W-1:0]             point_x,
    input  logic signed [POINT_W-1:0]             point_y,
    input  logic signed [POINT_W-1:0]             point_z,
    output logic signed [COORD_FRAC_BITS+3:0]     sample_value
);

    localparam int F  = COORD_FRAC_BITS;
    localparam int IW = $clog2(TABLE_SIZE);
    localparam int V  = F + 4;
    localparam logic [F+1:0] THREE_F = (F+2)'(3) << F;

    function automatic logic signed [V-1:0] lerp(input logic signed [V-1:0] a,
                                                 input logic signed [V-1:0] b,
                                                 input logic [F-1:0] s);
        logic signed [V:0]     diff;
        logic signed [V+F+1:0] prod;
        logic signed [V+1:0]   sum;
        diff = {b[V-1], b} - {a[V-1], a};
        prod = (V+F+2)'(diff) * $signed({2'b00, s});
        sum  = (V+2)'(a) + (V+2)'(prod >>> F);
        return sum[V-1:0];
    endfunction

    logic [7:0]    px_mem [TABLE_SIZE];
    logic [7:0]    py_mem [TABLE_SIZE];
    logic [7:0]    pz_mem [TABLE_SIZE];
    logic [47:0]   g_mem  [4][TABLE_SIZE];

    logic signed [POINT_W-1:0] pt [3];
    logic [IW-1:0] cell_reg [3];
    logic [F-1:0]  frac1_reg [3];

    logic [7:0]    perm_reg [3][2];
    logic [F-1:0]  f2_reg [3];
    logic [F-1:0]  frac2_reg [3];

    logic [47:0]   grad_reg [8];
    logic [F-1:0]  s3_reg [3];
    logic [F-1:0]  frac3_reg [3];

    logic signed [F+17:0] prod_reg [8][3];
    logic [F-1:0]  s4_reg [3];
    logic signed [V-1:0] val_reg [8];
    logic [F-1:0]  s5_reg [3];
    logic signed [V-1:0] ylerp_reg [4];
    logic [F-1:0]  s6_reg [2];
    logic signed [V-1:0] zlerp_reg [2];
    logic [F-1:0]  s7_reg;
    logic signed [V-1:0] res_reg;

    logic [IW-1:0] hash [8];
    logic [F+1:0]  herm_t [3];
    logic [2*F+1:0] herm_p [3];
    logic [2*F-1:0] sq [3];
    logic [QUERY_W-1:0] q [3];

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            q[a]      = QUERY_W'(pt[a]) << OCTAVE;
            sq[a]     = frac1_reg[a] * frac1_reg[a];
            herm_t[a] = THREE_F - {1'b0, frac2_reg[a], 1'b0};
            herm_p[a] = f2_reg[a] * herm_t[a];
        end
        for (int c = 0; c < 8; c++)
        begin
            hash[c] = IW'(perm_reg[0][c % 2] ^ perm_reg[1][(c / 2) % 2]
                          ^ perm_reg[2][c / 4]);
        end
    end

    // stage 1: lattice cell and fraction
    always_ff @(posedge clk)
    begin
        if (ctl.en[1])
        begin
            for (int a = 0; a < 3; a++)
            begin
                cell_reg[a]  <= q[a][F +: IW];
                frac1_reg[a] <= q[a][F-1:0];
            end
        end
    end

    // stage 2: permutation lookups, square of the fraction
    always_ff @(posedge clk)
    begin
        if (ctl.en[2])
        begin
            perm_reg[0][0] <= px_mem[cell_reg[0]];
            perm_reg[0][1] <= px_mem[cell_reg[0] + IW'(1)];
            perm_reg[1][0] <= py_mem[cell_reg[1]];
            perm_reg[1][1] <= py_mem[cell_reg[1] + IW'(1)];
            perm_reg[2][0] <= pz_mem[cell_reg[2]];
            perm_reg[2][1] <= pz_mem[cell_reg[2] + IW'(1)];
            for (int a = 0; a < 3; a++)
            begin
                f2_reg[a]    <= sq[a][2*F-1:F];
                frac2_reg[a] <= frac1_reg[a];
            end
            if (ctl.perm_we)
            begin
                px_mem[IW'(ctl.perm_idx)] <= ctl.perm_x;
                py_mem[IW'(ctl.perm_idx)] <= ctl.perm_y;
                pz_mem[IW'(ctl.perm_idx)] <= ctl.perm_z;
            end
        end
    end

    // stage 3: gradient lookups, two corners per copy, hermite weight
    always_ff @(posedge clk)
    begin
        if (ctl.en[3])
        begin
            for (int k = 0; k < 4; k++)
            begin
                grad_reg[2*k]   <= g_mem[k][hash[2*k]];
                grad_reg[2*k+1] <= g_mem[k][hash[2*k+1]];
                if (ctl.grad_we)
                begin
                    g_mem[k][IW'(ctl.grad_idx)] <= {ctl.grad_z, ctl.grad_y, ctl.grad_x};
                end
            end
            for (int a = 0; a < 3; a++)
            begin
                s3_reg[a]    <= herm_p[a][2*F-1:F];
                frac3_reg[a] <= frac2_reg[a];
            end
        end
    end

    // stage 4: gradient times offset
    always_ff @(posedge clk)
    begin
        logic signed [F+1:0] off;
        if (ctl.en[4])
        begin
            for (int c = 0; c < 8; c++)
            begin
                for (int d = 0; d < 3; d++)
                begin
                    off = $signed({2'b00, frac3_reg[d]});
                    if (((c >> d) & 1) == 1)
                    begin
                        off = off - ((F+2)'(1) << F);
                    end
                    prod_reg[c][d] <= $signed(grad_reg[c][16*d +: 16]) * off;
                end
            end
            s4_reg <= s3_reg;
        end
    end

    // stage 5: corner dot products
    always_ff @(posedge clk)
    begin
        logic signed [F+19:0] dsum;
        if (ctl.en[5])
        begin
            for (int c = 0; c < 8; c++)
            begin
                dsum = (F+20)'(prod_reg[c][0]) + (F+20)'(prod_reg[c][1])
                     + (F+20)'(prod_reg[c][2]);
                val_reg[c] <= V'(dsum >>> 14);
            end
            s5_reg <= s4_reg;
        end
    end

    // stages 6 to 8: interpolate along x, then y, then z
    always_ff @(posedge clk)
    begin
        if (ctl.en[6])
        begin
            for (int j = 0; j < 4; j++)
            begin
                ylerp_reg[j] <= lerp(val_reg[2*j], val_reg[2*j+1], s5_reg[0]);
            end
            s6_reg[0] <= s5_reg[1];
            s6_reg[1] <= s5_reg[2];
        end
        if (ctl.en[7])
        begin
            zlerp_reg[0] <= lerp(ylerp_reg[0], ylerp_reg[1], s6_reg[0]);
            zlerp_reg[1] <= lerp(ylerp_reg[2], ylerp_reg[3], s6_reg[0]);
            s7_reg       <= s6_reg[1];
        end
        if (ctl.en[8])
        begin
            res_reg <= lerp(zlerp_reg[0], zlerp_reg[1], s7_reg);
        end
    end

    assign sample_value = res_reg;

endmodule

// File: hdl/perlin_gradient_noise_3d.sv
// top level of the 3d perlin gradient noise and turbulence block
//
// input stream: s_tuser carries the command, s_tdata the table write or
// the sample point. gradient and permutation writes produce no result;
// every sample request produces one noise_value on the output stream.
// table writes travel down the pipeline and land at the stage where the
// tables are read, so requests see writes in stream order.
// ten register stages; m_tvalid rises once a sample reaches the last.
// one request per cycle is taken while s_tready is high; every octave
// has its own lane with its own copies of the tables, and each lane holds
// four gradient copies with two read ports each to serve the eight corners.
// each stage holds its data until the next one is free, so when the
// receiver stalls, bubbles in the pipeline are still filled and s_tready
// only drops once all ten stages are occupied. nothing is lost or repeated.
// reset clears valid bits and the two registers (mode 0, one octave); the
// tables keep whatever they held and must be loaded before sampling.
// registers: byte 0 turbulence_mode, byte 4 octave_count.
module perlin_gradient_noise_3d
    import pgn_pkg::*;
#(
    parameter int TABLE_SIZE      = TABLE_SIZE_DEF,
    parameter int MAX_OCTAVES     = MAX_OCTAVES_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // table_index, perm_x_value, perm_y_value, perm_z_value, grad_x, grad_y,
    // grad_z, point_x, point_y, point_z
    input  logic [175:0]  s_tdata,
    // command
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // noise_value
    output logic [23:0]   m_tdata,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int F  = COORD_FRAC_BITS;
    localparam int V  = F + 4;
    localparam int A  = V + MAX_OCTAVES + 1;
    localparam int SH = (F >= 16) ? F - 16 : 0;
    localparam int SL = (F < 16) ? 16 - F : 0;
    localparam int CW = $clog2(MAX_OCTAVES + 1) + 1;

    logic                  mode_reg;
    logic [3:0]            octave_reg;
    logic [NUM_STAGES:1]   v_reg;
    logic [NUM_STAGES:1]   rdy;
    logic [1:0]            cmd1_reg;
    logic [1:0]            cmd2_reg;
    logic [7:0]            idx1_reg;
    logic [7:0]            idx2_reg;
    logic [7:0]            perm1_reg [3];
    logic [47:0]           grad1_reg;
    logic [47:0]           grad2_reg;
    logic signed [A-1:0]   r9_reg;
    logic signed [A-1:0]   r9_next;
    logic [OUT_W-1:0]      noise_reg;
    logic [OUT_W-1:0]      noise_next;
    pgn_ctl_t              ctl;
    logic signed [V-1:0]   smp [MAX_OCTAVES];
    logic                  wr_en;

    // config port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            octave_reg <= 4'd1;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_MODE:   mode_reg   <= pwdata[0];
                REG_OCTAVE: octave_reg <= pwdata[3:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MODE:   prdata = {31'd0, mode_reg};
            REG_OCTAVE: prdata = {28'd0, octave_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // a stage takes new data when empty or when its successor moves
    always_comb
    begin
        rdy[NUM_STAGES] = !v_reg[NUM_STAGES] || m_tready;
        for (int k = NUM_STAGES - 1; k >= 1; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= NUM_STAGES; k++)
            begin
                if (rdy[k])
                begin
                    if (k == 1)
                        v_reg[k] <= s_tvalid;
                    else if (k == 3)
                        v_reg[k] <= v_reg[2] && (cmd2_reg == CMD_SAMPLE);
                    else
                        v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // write requests ride along until their tables' read stage
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            cmd1_reg     <= s_tuser;
            idx1_reg     <= s_tdata[7:0];
            perm1_reg[0] <= s_tdata[15:8];
            perm1_reg[1] <= s_tdata[23:16];
            perm1_reg[2] <= s_tdata[31:24];
            grad1_reg    <= s_tdata[79:32];
        end
        if (rdy[2])
        begin
            cmd2_reg  <= cmd1_reg;
            idx2_reg  <= idx1_reg;
            grad2_reg <= grad1_reg;
        end
    end

    always_comb
    begin
        ctl.en       = rdy[LANE_STAGES:1];
        ctl.perm_we  = v_reg[1] && (cmd1_reg == CMD_PERM);
        ctl.grad_we  = v_reg[2] && (cmd2_reg == CMD_GRAD);
        ctl.perm_idx = idx1_reg;
        ctl.grad_idx = idx2_reg;
        ctl.perm_x   = perm1_reg[0];
        ctl.perm_y   = perm1_reg[1];
        ctl.perm_z   = perm1_reg[2];
        ctl.grad_x   = grad2_reg[15:0];
        ctl.grad_y   = grad2_reg[31:16];
        ctl.grad_z   = grad2_reg[47:32];
    end

    for (genvar o = 0; o < MAX_OCTAVES; o++)
    begin : g_lane
        pgn_lane #(
            .TABLE_SIZE      (TABLE_SIZE),
            .COORD_FRAC_BITS (COORD_FRAC_BITS),
            .OCTAVE          (o)
        ) u_lane (
            .clk          (clk),
            .ctl          (ctl),
            .point_x      (s_tdata[111:80]),
            .point_y      (s_tdata[143:112]),
            .point_z      (s_tdata[175:144]),
            .sample_value (smp[o])
        );
    end

    // stage 9: octave 0 sample, or in turbulence mode the weighted octave sum and its magnitude
    always_comb
    begin
        logic [CW-1:0]       n;
        logic signed [A-1:0] acc;
        n = CW'(octave_reg);
        if (n == '0)
            n = CW'(1);
        if (n > CW'(MAX_OCTAVES))
            n = CW'(MAX_OCTAVES);
        acc = '0;
        for (int o = 0; o < MAX_OCTAVES; o++)
        begin
            if (CW'(o) < n)
                acc = acc + (A'(smp[o]) <<< (MAX_OCTAVES - 1 - o));
        end
        if (acc < 0)
            acc = -acc;
        if (mode_reg)
            r9_next = acc >>> (MAX_OCTAVES - 1);
        else
            r9_next = A'(smp[0]);
    end

    // stage 10: rescale to 16 fraction bits and saturate
    always_comb
    begin
        logic signed [A+SL-1:0] conv;
        conv = (A+SL)'(r9_reg >>> SH) <<< SL;
        if (conv > (A+SL)'(8388607))
            noise_next = 24'h7fffff;
        else if (conv < -(A+SL)'(8388608))
            noise_next = 24'h800000;
        else
            noise_next = conv[OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[9])
            r9_reg <= r9_next;
        if (rdy[10])
            noise_reg <= noise_next;
    end

    assign m_tvalid = v_reg[NUM_STAGES];
    assign m_tdata  = noise_reg;

endmodule

// File: hdl/pgn_checker.sv
// port-level checks for the perlin noise block, bound to the top level
module pgn_port_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [23:0]   m_tdata,
    input logic [31:0]   prdata,
    input logic          pready
);

    // an empty output stage means the whole chain can take a request
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("s_tready low while output is empty");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

    a_prdata_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:4] == 28'd0)
        else $error("register readback has stray bits");

endmodule

bind perlin_gradient_noise_3d pgn_port_checker u_pgn_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .prdata   (prdata),
    .pready   (pready)
);

// File: verif/pgn_checker.sv
// checker for the perlin noise block: table shadow, noise prediction and result compare
module pgn_checker
    import pgn_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [175:0]  s_tdata,
    input  logic [1:0]    s_tuser,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [23:0]   m_tdata,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic          pready,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output int            fail_count,
    output int            pending
);

    logic signed [15:0] grad_tab [256][3];
    logic [7:0]         perm_x_tab [256];
    logic [7:0]         perm_y_tab [256];
    logic [7:0]         perm_z_tab [256];
    logic               turb_mode;
    logic [3:0]         octaves;
    logic [23:0]        noise_q [$];

    function automatic longint hermite_w(longint f);
        longint f2;
        f2 = (f * f) >>> 16;
        return (f2 * (3 * 65536 - 2 * f)) >>> 16;
    endfunction

    function automatic longint lerp_q(longint a, longint b, longint s);
        return a + (((b - a) * s) >>> 16);
    endfunction

    // one noise sample in q.16 for 64-bit wrapped coordinates
    function automatic longint noise_at(logic [63:0] px, logic [63:0] py, logic [63:0] pz);
        longint   fx, fy, fz, sx, sy, sz, dot, y00, y10, y01, y11, z0, z1;
        longint   v [2][2][2];
        logic [7:0] h;
        fx = longint'(px[15:0]);
        fy = longint'(py[15:0]);
        fz = longint'(pz[15:0]);
        sx = hermite_w(fx);
        sy = hermite_w(fy);
        sz = hermite_w(fz);
        for (int a = 0; a < 2; a++)
            for (int b = 0; b < 2; b++)
                for (int c = 0; c < 2; c++)
                begin
                    h = perm_x_tab[8'(px[23:16] + a)] ^ perm_y_tab[8'(py[23:16] + b)]
                        ^ perm_z_tab[8'(pz[23:16] + c)];
                    dot = longint'(grad_tab[h][0]) * (fx - a * 65536)
                        + longint'(grad_tab[h][1]) * (fy - b * 65536)
                        + longint'(grad_tab[h][2]) * (fz - c * 65536);
                    v[a][b][c] = dot >>> 14;
                end
        y00 = lerp_q(v[0][0][0], v[1][0][0], sx);
        y10 = lerp_q(v[0][1][0], v[1][1][0], sx);
        y01 = lerp_q(v[0][0][1], v[1][0][1], sx);
        y11 = lerp_q(v[0][1][1], v[1][1][1], sx);
        z0  = lerp_q(y00, y10, sy);
        z1  = lerp_q(y01, y11, sy);
        return lerp_q(z0, z1, sz);
    endfunction

    function automatic logic [23:0] noise_value_of(logic [175:0] d);
        logic [63:0] px, py, pz;
        longint      acc, r;
        int          n;
        px = {{32{d[111]}}, d[111:80]};
        py = {{32{d[143]}}, d[143:112]};
        pz = {{32{d[175]}}, d[175:144]};
        if (!turb_mode)
            r = noise_at(px, py, pz);
        else
        begin
            n = (octaves == 0) ? 1 : (octaves > 8) ? 8 : int'(octaves);
            acc = 0;
            for (int o = 0; o < n; o++)
                acc += noise_at(px << o, py << o, pz << o) * (longint'(1) << (7 - o));
            if (acc < 0)
                acc = -acc;
            r = acc >>> 7;
        end
        if (r > 8388607)
            r = 8388607;
        if (r < -8388608)
            r = -8388608;
        return r[23:0];
    endfunction

    assign pending = noise_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turb_mode  <= 1'b0;
            octaves    <= 4'd1;
            fail_count <= 0;
            noise_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_OCTAVE)
                    octaves <= pwdata[3:0];
                else
                    turb_mode <= pwdata[0];
            end
            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    CMD_GRAD:
                    begin
                        grad_tab[s_tdata[7:0]][0] = s_tdata[47:32];
                        grad_tab[s_tdata[7:0]][1] = s_tdata[63:48];
                        grad_tab[s_tdata[7:0]][2] = s_tdata[79:64];
                    end
                    CMD_PERM:
                    begin
                        perm_x_tab[s_tdata[7:0]] = s_tdata[15:8];
                        perm_y_tab[s_tdata[7:0]] = s_tdata[23:16];
                        perm_z_tab[s_tdata[7:0]] = s_tdata[31:24];
                    end
                    CMD_SAMPLE: noise_q.push_back(noise_value_of(s_tdata));
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (noise_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                    fail_count <= fail_count + 1;
                end
                else if (noise_q[0] !== m_tdata)
                begin
                    $display("%0t: noise_value mismatch, expected %h, actual %h",
                             $time, noise_q[0], m_tdata);
                    fail_count <= fail_count + 1;
                    void'(noise_q.pop_front());
                end
                else
                    void'(noise_q.pop_front());
            end
        end
    end

endmodule

// File: verif/tb_perlin_gradient_noise_3d.sv
// testbench top for the perlin noise block: stimulus, handshake idling and verdict
module tb_perlin_gradient_noise_3d
    import pgn_pkg::*;
();

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [175:0]  s_tdata;
    logic [1:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [23:0]   m_tdata;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;
    int            fail_count;
    int            pending;
    int            cycles;
    bit            quiet;

    localparam int CYCLE_LIMIT = 400000;

    perlin_gradient_noise_3d u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    pgn_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic bit take_gap();
        return !quiet && ($urandom_range(99) < 14);
    endfunction

    always @(posedge clk)
        m_tready <= !take_gap();

    task automatic send_request(logic [1:0] cmd, logic [175:0] d);
        if (take_gap())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [175:0] grad_word(logic [7:0] idx, logic [15:0] gx,
                                               logic [15:0] gy, logic [15:0] gz);
        return {96'd0, gz, gy, gx, 24'd0, idx};
    endfunction

    function automatic logic [175:0] perm_word(logic [7:0] idx, logic [7:0] x,
                                               logic [7:0] y, logic [7:0] z);
        return {144'd0, z, y, x, idx};
    endfunction

    function automatic logic [175:0] point_word(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        return {z, y, x, 80'd0};
    endfunction

    function automatic logic [15:0] rand_grad();
        return 16'($urandom_range(32768) - 16384);
    endfunction

    // lets the pipeline drain, table writes included, before a register change
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (14) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            send_request(CMD_GRAD, grad_word(8'($urandom), rand_grad(), rand_grad(), rand_grad()));
        else if (pick < 27)
            send_request(CMD_PERM, perm_word(8'($urandom), 8'($urandom), 8'($urandom),
                                             8'($urandom)));
        else if (pick < 30)
            send_request(CMD_NONE, {$urandom, $urandom, $urandom, $urandom, $urandom,
                                    16'($urandom)});
        else if (pick < 45)
            // points near the origin keep octave doubling inside small lattice ranges
            send_request(CMD_SAMPLE, point_word(32'($urandom_range(2000000) - 1000000),
                                                32'($urandom_range(2000000) - 1000000),
                                                32'($urandom_range(2000000) - 1000000)));
        else
            send_request(CMD_SAMPLE, point_word($urandom, $urandom, $urandom));
    endtask

    logic [31:0] oct_plan [6] = '{32'd1, 32'd8, 32'd0, 32'd15, 32'd3, 32'd5};
    logic [31:0] mode_plan [6] = '{32'd0, 32'd1, 32'd1, 32'd1, 32'd1, 32'd0};

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        quiet    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every table entry is loaded before any sample can read it
        for (int i = 0; i < 256; i++)
        begin
            send_request(CMD_PERM, perm_word(8'(i), 8'($urandom), 8'($urandom), 8'($urandom)));
            case (i)
                0:       send_request(CMD_GRAD, grad_word(8'(i), 16'sd16384, 16'sd16384,
                                                          16'sd16384));
                1:       send_request(CMD_GRAD, grad_word(8'(i), -16'sd16384, -16'sd16384,
                                                          -16'sd16384));
                2:       send_request(CMD_GRAD, grad_word(8'(i), 16'd0, 16'd0, 16'd0));
                default: send_request(CMD_GRAD, grad_word(8'(i), rand_grad(), rand_grad(),
                                                          rand_grad()));
            endcase
        end

        // directed samples: lattice points, fraction extremes, coordinate extremes
        send_request(CMD_SAMPLE, point_word(32'h0, 32'h0, 32'h0));
        send_request(CMD_SAMPLE, point_word(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        send_request(CMD_SAMPLE, point_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_request(CMD_SAMPLE, point_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_request(CMD_SAMPLE, point_word(32'h0001_0000, 32'h00ff_0000, 32'hff00_0000));
        send_request(CMD_SAMPLE, point_word(32'h0000_ffff, 32'h0000_8000, 32'h0000_0001));
        send_request(CMD_SAMPLE, point_word(32'h00ff_ffff, 32'h0100_0000, 32'hfeff_8000));
        send_request(CMD_NONE, {176{1'b1}});
        send_request(CMD_SAMPLE, point_word(32'h1234_5678, 32'h8765_4321, 32'h0f0f_f0f0));

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            reg_write({REG_MODE, 2'b00}, mode_plan[ph]);
            reg_write({REG_OCTAVE, 2'b00}, (ph == 5) ? 32'($urandom_range(1, 8)) : oct_plan[ph]);
            send_request(CMD_SAMPLE, point_word(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff));
            for (int n = 0; n < 180; n++)
            begin
                quiet = (ph == 2);
                if (ph == 3 && n == 130)
                begin
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0)
                        @(posedge clk);
                end
                random_request();
            end
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
